/* hdl/rnm_pkg.sv */
// Shared types and constants for the Rulkov map neuron step block.
// Used by the top level; no dependencies.
package rnm_pkg;

    // Default word and fraction widths of the fixed-point format
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;

    // Configuration port index width (seven registers)
    localparam int CFG_IDX_BITS = 3;

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ALPHA    = 3'd0,
        CFG_BETA     = 3'd1,
        CFG_MU       = 3'd2,
        CFG_SIGMA    = 3'd3,
        CFG_START_X  = 3'd4,
        CFG_START_Y  = 3'd5,
        CFG_USE_STAT = 3'd6
    } t_cfg_idx;

    // Reset values as 32-bit patterns, sign-extended or cut to the word width
    localparam logic signed [31:0] RST_ALPHA   = 32'sd100663296;
    localparam logic signed [31:0] RST_BETA    = 32'sd0;
    localparam logic signed [31:0] RST_MU      = 32'sd16777;
    localparam logic signed [31:0] RST_SIGMA   = 32'sd0;
    localparam logic signed [31:0] RST_START_X = -32'sd16777216;
    localparam logic signed [31:0] RST_START_Y = -32'sd50331648;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_MUL_X = 3'd1,
        S_MUL_S = 3'd2,
        S_DIV   = 3'd3,
        S_ADD1  = 3'd4,
        S_ADD2  = 3'd5,
        S_EMIT  = 3'd6
    } t_state;

endpackage

/* hdl/rnm_in_if.sv */
// Input channel of the neuron step block: valid/ready plus the restart flag.
// No dependencies.
interface rnm_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

/* hdl/rnm_out_if.sv */
// Output channel of the neuron step block: valid/ready plus x, y and step index.
// No dependencies.
interface rnm_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] x_out;
    logic signed [W-1:0] y_out;
    logic        [31:0]  step_index;

    modport source (output valid, output x_out, output y_out, output step_index, input ready);
    modport sink (input valid, input x_out, input y_out, input step_index, output ready);
endinterface

/* hdl/rulkov_neuron_map_step.sv */
// Top level of the Rulkov map neuron step: configuration registers, state,
// sequencer and saturating adds. Uses rnm_pkg, rnm_in_if, rnm_out_if,
// rnm_mul and rnm_div.
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      restart
//  o_out     out  valid / ready      x_out, y_out, step_index
//  cfg       in   i_cfg_we only      i_cfg_idx, i_cfg_data
//
// A word passes through two bit-serial products, mu*(x+1) then mu*sigma, two add
// states and the output load, with the divider running alongside. i_in.ready is
// high only while idle, so a new word is not taken before the last one is through
// the sequencer; a finished word waits in the output register and a second one
// holds the sequencer until it leaves. Sync active-low reset.
module rulkov_neuron_map_step #(
    parameter int WORD_BITS = rnm_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rnm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rnm_in_if.sink                            i_in,
    rnm_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [rnm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [WORD_BITS-1:0]              i_cfg_data
);
    import rnm_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] VMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN    = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_V   = (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : VMAX;
    localparam logic [W-1:0] NEG_ONE = ~ONE_V + 1'b1;

    localparam logic [63:0] EXT_ALPHA = 64'(RST_ALPHA);
    localparam logic [63:0] EXT_BETA  = 64'(RST_BETA);
    localparam logic [63:0] EXT_MU    = 64'(RST_MU);
    localparam logic [63:0] EXT_SIGMA = 64'(RST_SIGMA);
    localparam logic [63:0] EXT_SX    = 64'(RST_START_X);
    localparam logic [63:0] EXT_SY    = 64'(RST_START_Y);

    // Saturating add and subtract on the word
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return s[W-1:0];
    endfunction

    // Configuration registers
    logic [W-1:0] r_alpha, r_beta, r_mu, r_sigma, r_sx, r_sy;
    logic         r_stat;

    // Neuron state and work registers
    t_state       r_state, n_state;
    logic [W-1:0] r_x, r_y;
    logic [31:0]  r_cnt;
    logic         r_rst_item;
    logic [W-1:0] r_px, r_ps, r_yb, r_t, r_s, r_nxd, r_ny;
    logic         r_qv;

    // Output register
    logic         r_ov;
    logic [W-1:0] r_ox, r_oy;
    logic [31:0]  r_oc;

    // Sequencer outputs
    logic         in_ready;
    logic         accept;
    logic         mul_start;
    logic [W-1:0] mul_b;
    logic         div_start;
    logic         emit_load;

    logic [W-1:0] x_eff;
    logic [W-1:0] x_p1;
    logic [W-1:0] nx;
    logic         mul_done, div_done;
    logic [W-1:0] mul_prod, div_quo;

    assign accept = i_in.valid && in_ready;
    assign x_eff  = i_in.restart ? r_sx : r_x;
    assign x_p1   = sat_add(x_eff, ONE_V);

    // Next fast variable by the sign of x and the compare against alpha+y+beta
    always_comb begin
        if ($signed(r_x) <= $signed({W{1'b0}})) begin
            nx = r_nxd;
        end else if ($signed(r_x) < $signed(r_s)) begin
            nx = r_s;
        end else begin
            nx = NEG_ONE;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_MUL_X;
            S_MUL_X: if (mul_done) n_state = S_MUL_S;
            S_MUL_S: if (mul_done) n_state = S_DIV;
            S_DIV:   if (r_qv) n_state = S_ADD1;
            S_ADD1:  n_state = S_ADD2;
            S_ADD2:  n_state = S_EMIT;
            S_EMIT:  if (!r_ov || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        mul_b     = x_p1;
        div_start = 1'b0;
        emit_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready  = 1'b1;
                mul_start = accept;
                div_start = accept;
            end
            S_MUL_X: begin
                mul_start = mul_done;
                mul_b     = r_sigma;
            end
            S_EMIT: begin
                emit_load = !r_ov || o_out.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Shared multiplier: mu*(x+1), then mu*sigma
    rnm_mul #(
        .W (W),
        .F (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_mu),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Divider for alpha/(1-x)
    rnm_div #(
        .W (W),
        .F (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_alpha (r_alpha),
        .i_x     (x_eff),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= EXT_ALPHA[W-1:0];
            r_beta  <= EXT_BETA[W-1:0];
            r_mu    <= EXT_MU[W-1:0];
            r_sigma <= EXT_SIGMA[W-1:0];
            r_sx    <= EXT_SX[W-1:0];
            r_sy    <= EXT_SY[W-1:0];
            r_stat  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:    r_alpha <= i_cfg_data;
                CFG_BETA:     r_beta  <= i_cfg_data;
                CFG_MU:       r_mu    <= i_cfg_data;
                CFG_SIGMA:    r_sigma <= i_cfg_data;
                CFG_START_X:  r_sx    <= i_cfg_data;
                CFG_START_Y:  r_sy    <= i_cfg_data;
                CFG_USE_STAT: r_stat  <= i_cfg_data[0];
                default:      r_stat  <= r_stat;
            endcase
        end
    end

    // Sequencer, neuron state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x     <= EXT_SX[W-1:0];
            r_y     <= EXT_SY[W-1:0];
            r_cnt   <= '0;
            r_qv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            // track quotient availability
            if (div_start) begin
                r_qv <= 1'b0;
            end else if (div_done) begin
                r_qv <= 1'b1;
            end
            // restart reloads the state before the step
            if (accept && i_in.restart) begin
                r_x   <= r_sx;
                r_y   <= r_sy;
                r_cnt <= '0;
            end
            // stationary y on a restart word once both products are known
            if (r_state == S_MUL_S && mul_done && r_rst_item && r_stat) begin
                r_y <= sat_sub(mul_prod, r_px);
            end
            // advance the neuron when the word is loaded into the output register
            if (emit_load) begin
                r_x   <= nx;
                r_y   <= r_ny;
                r_cnt <= r_cnt + 1'b1;
            end
            if (emit_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Work registers and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rst_item <= i_in.restart;
        end
        if (r_state == S_MUL_X && mul_done) begin
            r_px <= mul_prod;
        end
        if (r_state == S_MUL_S && mul_done) begin
            r_ps <= mul_prod;
        end
        if (r_state == S_ADD1) begin
            r_yb <= sat_add(r_y, r_beta);
            r_t  <= sat_sub(r_y, r_px);
        end
        if (r_state == S_ADD2) begin
            r_s   <= sat_add(r_alpha, r_yb);
            r_nxd <= sat_add(div_quo, r_yb);
            r_ny  <= sat_add(r_t, r_ps);
        end
        if (emit_load) begin
            r_ox <= r_x;
            r_oy <= r_y;
            r_oc <= r_cnt;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.x_out      = r_ox;
    assign o_out.y_out      = r_oy;
    assign o_out.step_index = r_oc;
endmodule

/* hdl/rnm_mul.sv */
// Bit-serial signed fixed-point multiplier: one shift-add per cycle, then
// shift by the fraction width and saturate. No dependencies.
module rnm_mul #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_prod
);
    localparam int CW = $clog2(W + 1);
    localparam logic [2*W-1:0] LIM_POS = {{W{1'b0}}, 1'b0, {(W-1){1'b1}}};
    localparam logic [2*W-1:0] LIM_NEG = LIM_POS + 1'b1;
    localparam logic [W-1:0]   VMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   VMIN    = {1'b1, {(W-1){1'b0}}};

    logic            r_busy;
    logic            r_fin;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_ua;
    logic [2*W-1:0]  r_p;
    logic            r_neg;
    logic [W-1:0]    r_prod;

    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;
    logic [W:0]      sum;
    logic [2*W-1:0]  q;
    logic            over;

    // Magnitudes of the operands
    assign mag_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;

    // One partial product per cycle
    assign sum = {1'b0, r_p[2*W-1:W]} + (r_p[0] ? {1'b0, r_ua} : {(W+1){1'b0}});

    // Scale and range check
    assign q    = r_p >> F;
    assign over = r_neg ? (q > LIM_NEG) : (q > LIM_POS);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= mag_a;
            r_p   <= {{W{1'b0}}, mag_b};
            r_neg <= i_a[W-1] ^ i_b[W-1];
        end else if (r_busy) begin
            r_p <= {sum, r_p[W-1:1]};
        end
        if (r_fin) begin
            if (over) begin
                r_prod <= r_neg ? VMIN : VMAX;
            end else begin
                r_prod <= r_neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

/* hdl/rnm_div.sv */
// Restoring divider for alpha * 2^F / (1 - x), x <= 0: one quotient bit per
// cycle, then saturate to the word range. No dependencies.
module rnm_div #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_alpha,
    input  logic signed [W-1:0] i_x,
    output logic                o_done,
    output logic signed [W-1:0] o_quo
);
    localparam int NB = W + F;
    localparam int DW = ((F + 1 > W) ? F + 1 : W) + 1;
    localparam int CB = $clog2(NB + 1);
    localparam logic [NB-1:0] LIM_POS = NB'({1'b0, {(W-1){1'b1}}});
    localparam logic [NB-1:0] LIM_NEG = LIM_POS + 1'b1;
    localparam logic [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};
    localparam logic [DW-1:0] ONE_D   = DW'(1) << F;

    logic            r_busy;
    logic            r_fin;
    logic            r_done;
    logic [CB-1:0]   r_cnt;
    logic [NB-1:0]   r_nq;
    logic [DW-1:0]   r_r;
    logic [DW-1:0]   r_d;
    logic            r_neg;
    logic [W-1:0]    r_quo;

    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_x;
    logic [DW:0]     r2;
    logic [DW:0]     diff;
    logic            ge;
    logic            over;

    assign mag_a = i_alpha[W-1] ? (~i_alpha + 1'b1) : i_alpha;
    assign mag_x = i_x[W-1] ? (~i_x + 1'b1) : i_x;

    // Shift in the next numerator bit and trial-subtract the divisor
    assign r2   = {r_r, r_nq[NB-1]};
    assign diff = r2 - {1'b0, r_d};
    assign ge   = (r2 >= {1'b0, r_d});

    assign over = r_neg ? (r_nq > LIM_NEG) : (r_nq > LIM_POS);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out on top while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= {mag_a, {F{1'b0}}};
            r_r   <= '0;
            r_d   <= ONE_D + DW'(mag_x);
            r_neg <= i_alpha[W-1];
        end else if (r_busy) begin
            r_r  <= ge ? diff[DW-1:0] : r2[DW-1:0];
            r_nq <= {r_nq[NB-2:0], ge};
        end
        if (r_fin) begin
            if (over) begin
                r_quo <= r_neg ? VMIN : VMAX;
            end else begin
                r_quo <= r_neg ? (~r_nq[W-1:0] + 1'b1) : r_nq[W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* sim/rulkov_neuron_map_step_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for rulkov_neuron_map_step: drives restart words, predicts
// x, y and step index in Q8.24, and compares every result word in order.
// Depends on rnm_pkg, rnm_in_if, rnm_out_if and the block itself.
module rulkov_neuron_map_step_test;
    import rnm_pkg::*;

    localparam int WORD = WORD_BITS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint FIX_MAX = (64'sd1 <<< (WORD - 1)) - 1;
    localparam longint FIX_MIN = -FIX_MAX - 1;
    localparam longint ONE_RAW = 64'sd1 <<< FRAC;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
    localparam int RANDOM_TICKS = 660;
    localparam int LONG_STALL = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 2 * WORD + 8;

    typedef logic signed [WORD-1:0] t_fix;
    typedef struct {
        t_fix        x;
        t_fix        y;
        logic [31:0] step;
    } t_neuron_sample;

    localparam t_fix ONE = t_fix'(ONE_RAW);
    localparam t_fix NEG_ONE = t_fix'(-ONE_RAW);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [WORD-1:0]         cfg_data;

    rnm_in_if in_ch ();
    rnm_out_if #(.W(WORD)) out_ch ();

    rulkov_neuron_map_step #(
        .WORD_BITS(WORD),
        .FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Register copy and neuron state as the block should hold them
    t_fix        cur_alpha, cur_beta, cur_mu, cur_sigma, cur_start_x, cur_start_y;
    logic        cur_use_stat;
    t_fix        fast_v, slow_v;
    logic [31:0] tick_no;

    bit             restart_q[$];
    t_neuron_sample trace_q[$];

    int send_idle_pct, recv_idle_pct;
    bit stall_req;
    int stall_left;
    int quiet_cycles;
    int error_count, ticks_sent, results_checked, restart_ticks, settings_loaded;
    int div_steps, linear_steps, reset_steps;

    function automatic t_fix sat_word(input longint v);
        if (v > FIX_MAX) return t_fix'(FIX_MAX);
        if (v < FIX_MIN) return t_fix'(FIX_MIN);
        return t_fix'(v);
    endfunction

    function automatic t_fix sat_sum(input t_fix a, input t_fix b);
        return sat_word(longint'(a) + longint'(b));
    endfunction

    function automatic t_fix sat_diff(input t_fix a, input t_fix b);
        return sat_word(longint'(a) - longint'(b));
    endfunction

    // Exact product, then drop the fraction bits rounding toward zero
    function automatic t_fix fix_mul(input t_fix a, input t_fix b);
        longint prod;
        longint mag;
        prod = longint'(a) * longint'(b);
        mag = (prod < 0) ? -prod : prod;
        mag = mag >>> FRAC;
        return sat_word((prod < 0) ? -mag : mag);
    endfunction

    // alpha / (1 - x) for x <= 0, truncated toward zero
    function automatic t_fix fix_div(input t_fix a, input t_fix x);
        longint num;
        longint den;
        longint quo;
        num = longint'(a);
        if (num < 0) num = -num;
        num = num <<< FRAC;
        den = ONE_RAW - longint'(x);
        quo = num / den;
        return sat_word((a < 0) ? -quo : quo);
    endfunction

    // Emit the current state for one tick, then advance the map
    function automatic void advance_neuron(input logic restart);
        t_neuron_sample sample;
        t_fix yb, lin, nx, ny;
        if (restart) begin
            fast_v = cur_start_x;
            slow_v = cur_use_stat ?
                sat_diff(fix_mul(cur_mu, cur_sigma),
                         fix_mul(cur_mu, sat_sum(cur_start_x, ONE))) : cur_start_y;
            tick_no = '0;
            restart_ticks++;
        end
        sample.x = fast_v;
        sample.y = slow_v;
        sample.step = tick_no;
        trace_q.push_back(sample);

        yb = sat_sum(slow_v, cur_beta);
        lin = sat_sum(cur_alpha, yb);
        if (fast_v <= 0) begin
            nx = sat_sum(fix_div(cur_alpha, fast_v), yb);
            div_steps++;
        end else if (fast_v < lin) begin
            nx = lin;
            linear_steps++;
        end else begin
            nx = NEG_ONE;
            reset_steps++;
        end
        ny = sat_sum(sat_diff(slow_v, fix_mul(cur_mu, sat_sum(fast_v, ONE))),
                     fix_mul(cur_mu, cur_sigma));
        fast_v = nx;
        slow_v = ny;
        tick_no = tick_no + 1;
    endfunction

    // Random register value: mostly in a useful range, sometimes raw or extreme
    function automatic logic [WORD-1:0] pick_fix(input longint lo, input longint hi);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return t_fix'(FIX_MAX);
                    1: return t_fix'(FIX_MIN);
                    2: return '0;
                    3: return ONE;
                    default: return NEG_ONE;
                endcase
            end
            1: return $urandom();
            default: return t_fix'(lo + longint'($urandom_range(32'(hi - lo))));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WORD-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            CFG_ALPHA:    cur_alpha = value;
            CFG_BETA:     cur_beta = value;
            CFG_MU:       cur_mu = value;
            CFG_SIGMA:    cur_sigma = value;
            CFG_START_X:  cur_start_x = value;
            CFG_START_Y:  cur_start_y = value;
            CFG_USE_STAT: cur_use_stat = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [WORD-1:0] a, b, m, s, sx, sy, stat_word);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_BETA, b);
        write_reg(CFG_MU, m);
        write_reg(CFG_SIGMA, s);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
        write_reg(CFG_USE_STAT, stat_word);
        // the spare index must leave every register alone
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom());
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Wait until every queued word went in and every result came back
    task automatic drain();
        do @(negedge i_clk);
        while (restart_q.size() != 0 || in_ch.valid || trace_q.size() != 0);
    endtask

    // Queue n restart words, bit i of pattern for word i, and wait for them
    task automatic play(input logic [31:0] pattern, input int n);
        @(negedge i_clk);
        for (int i = 0; i < n; i++) restart_q.push_back(pattern[i]);
        drain();
    endtask

    // Driver: hold a word until taken, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.restart <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                advance_neuron(in_ch.restart);
                ticks_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (restart_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.restart <= restart_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                    in_ch.restart <= $urandom_range(1);
                end
            end
        end
    end

    // Monitor: check each result word against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_neuron_sample want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (trace_q.size() == 0) begin
                    $error("unexpected result word: x_out %0d y_out %0d step_index %0d",
                           out_ch.x_out, out_ch.y_out, out_ch.step_index);
                    error_count++;
                end else begin
                    want = trace_q.pop_front();
                    results_checked++;
                    if (out_ch.x_out !== want.x) begin
                        $error("x_out: expected %0d, actual %0d", want.x, out_ch.x_out);
                        error_count++;
                    end
                    if (out_ch.y_out !== want.y) begin
                        $error("y_out: expected %0d, actual %0d", want.y, out_ch.y_out);
                        error_count++;
                    end
                    if (out_ch.step_index !== want.step) begin
                        $error("step_index: expected %0d, actual %0d",
                               want.step, out_ch.step_index);
                        error_count++;
                    end
                end
            end
            // hold off for a long stretch on request, else stall at random
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (stall_req) begin
                out_ch.ready <= 1'b0;
                stall_left <= LONG_STALL;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Count cycles in which no word moves on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        do @(negedge i_clk);
        while (quiet_cycles < QUIET_LIMIT);
        $error("no word moved for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : main
        int sent;
        int len;
        bit noisy;
        bit long_stall_done;

        // known values on every input from time zero
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ALPHA;
        cfg_data = '0;
        stall_req = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 69;
        cur_alpha = RST_ALPHA;
        cur_beta = RST_BETA;
        cur_mu = RST_MU;
        cur_sigma = RST_SIGMA;
        cur_start_x = RST_START_X;
        cur_start_y = RST_START_Y;
        cur_use_stat = 1'b0;
        fast_v = RST_START_X;
        slow_v = RST_START_Y;
        tick_no = '0;
        long_stall_done = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state first, then a restart from the default registers
        play(32'b0010000, 7);
        // positive start below alpha+y+beta: linear branch, then back to -1
        load_settings(t_fix'(6 * ONE_RAW), t_fix'(ONE_RAW / 2), 32'sd167772, 32'sd5033165,
                      t_fix'(ONE_RAW / 2), t_fix'(-3 * ONE_RAW), 32'h0);
        play(32'b0001, 4);
        // x exactly zero, stationary y, upper data bits masked off
        load_settings(t_fix'(6 * ONE_RAW), '0, 32'sd167772, 32'sd5033165,
                      '0, t_fix'(-3 * ONE_RAW), 32'h8000_0001);
        play(32'b01, 2);
        // everything at the top of the range
        load_settings(t_fix'(FIX_MAX), t_fix'(FIX_MAX), t_fix'(FIX_MAX), t_fix'(FIX_MAX),
                      t_fix'(FIX_MAX), t_fix'(FIX_MAX), 32'h0);
        play(32'b001, 3);
        // everything but sigma at the bottom, stationary y
        load_settings(t_fix'(FIX_MIN), t_fix'(FIX_MIN), t_fix'(FIX_MIN), t_fix'(FIX_MAX),
                      t_fix'(FIX_MIN), t_fix'(FIX_MIN), 32'h1);
        play(32'b001, 3);
        // negative alpha with a large positive start
        load_settings(t_fix'(FIX_MIN), t_fix'(-ONE_RAW), t_fix'(ONE_RAW), t_fix'(FIX_MIN),
                      t_fix'(FIX_MAX), t_fix'(ONE_RAW), 32'hFFFF_FFFE);
        play(32'b01, 2);

        // random settings, each followed by a sequence that mostly starts clean
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            if (sent >= 2 * RANDOM_TICKS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent >= RANDOM_TICKS / 3) begin
                send_idle_pct = 69;
                recv_idle_pct = 11;
            end
            load_settings(pick_fix(ONE_RAW, 7 * ONE_RAW),
                          pick_fix(-ONE_RAW / 2, ONE_RAW / 2),
                          pick_fix(0, ONE_RAW / 20),
                          pick_fix(-ONE_RAW, ONE_RAW),
                          pick_fix(-2 * ONE_RAW, ONE_RAW),
                          pick_fix(-4 * ONE_RAW, -2 * ONE_RAW),
                          $urandom());
            len = $urandom_range(50, 30);
            noisy = ($urandom_range(9) == 0);
            @(negedge i_clk);
            for (int i = 0; i < len; i++)
                restart_q.push_back(noisy ? ($urandom_range(2) == 0)
                                          : (i == 0 || $urandom_range(24) == 0));
            // block the result side while words keep coming, once
            if (!long_stall_done && send_idle_pct == 0) begin
                stall_req = 1'b1;
                @(negedge i_clk);
                stall_req = 1'b0;
                long_stall_done = 1'b1;
            end
            drain();
            sent += len;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d ticks (%0d restarts) over %0d register settings, %0d results checked.",
                 ticks_sent, restart_ticks, settings_loaded, results_checked);
        $display("Update branches: divide %0d, linear %0d, reset to -1 %0d; %0d mismatches.",
                 div_steps, linear_steps, reset_steps, error_count);
        if (error_count == 0 && trace_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
